[hdl/gei_pkg.sv]
package gei_pkg;

  localparam int ENTRY_DEPTH_DEF = 256;
  localparam int BLOCK_DEPTH_DEF = 64;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_REBUILD = 2'd1;
  localparam logic [1:0] CMD_SPAN    = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FINAL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic CFG_LIMIT  = 1'b0;
  localparam logic CFG_BLOCKS = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RESP   = 8'b0000_0010,
    S_CLR    = 8'b0000_0100,
    S_ROWI   = 8'b0000_1000,
    S_ROWD   = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_PUT    = 8'b0100_0000,
    S_PFX_RD = 8'b1000_0000
  } state_t;

endpackage

[hdl/gei_ram.sv]
module gei_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

[hdl/gei_ent_mem.sv]
module gei_ent_mem #(
  parameter int W = 33,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra_a,
  output logic [W-1:0]         rd_a,
  input  logic [$clog2(D)-1:0] ra_b,
  output logic [W-1:0]         rd_b
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

[hdl/block_grouped_entry_index_core.sv]
// Add, span query and sorted read are accepted in S_IDLE and answered from
// S_RESP, which registers the result once the output is free; no new item is
// accepted until then, and input waits while a rebuild runs. A rebuild clears
// the span table, ranks each live entry by a scan over all entries, then
// sums block counts into span starts. Reset clears counters and flags; entry
// and sort memories are not cleared; each rebuild clears the span memory.
module block_grouped_entry_index_core #(
  parameter int ENTRY_DEPTH = gei_pkg::ENTRY_DEPTH_DEF,
  parameter int BLOCK_DEPTH = gei_pkg::BLOCK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // block_id[15:0], order[31:16], deleted[32], position[40:33]
  input  logic [47:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], entry_id[9:2], span_start[18:10], span_count[27:19],
  // live_count[36:28], is_final[37], limit_hit[38]
  output logic [39:0] m_tdata
);

  localparam int EAW = $clog2(ENTRY_DEPTH);
  localparam int CW  = $clog2(ENTRY_DEPTH + 1);
  localparam int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int BCW = $clog2(BLOCK_DEPTH + 1);
  localparam int BD  = (BLOCK_DEPTH > 1) ? BLOCK_DEPTH : 2;
  localparam int EW  = 33;
  localparam int SW  = 2 * CW;

  gei_pkg::state_t state;

  logic [8:0]     entry_limit;
  logic [BCW-1:0] blocks_cfg;
  logic [CW-1:0]  entry_total;
  logic [CW-1:0]  live_total;
  logic [BCW-1:0] span_total;
  logic           final_flag;
  logic           limit_flag;
  logic           ne_any;
  logic [BCW-1:0] last_ne;

  logic [1:0]     cmd;
  logic [15:0]    q_blk;
  logic [7:0]     q_pos;
  logic [1:0]     res_status;
  logic [7:0]     res_id;

  logic [CW-1:0]  i;
  logic [CW-1:0]  j;
  logic [CW-1:0]  pj;
  logic           pv;
  logic [CW-1:0]  rank;
  logic [CW-1:0]  live_n;
  logic [BCW-1:0] b;
  logic           pfx_wr;
  logic [CW-1:0]  prefix;

  logic [1:0]     s_cmd;
  logic [15:0]    s_block;
  logic [15:0]    s_order;
  logic           s_del;
  logic [7:0]     s_pos;
  logic           s_acc;

  logic           ent_we;
  logic [EW-1:0]  ent_rd_a;
  logic [EW-1:0]  ent_rd_b;
  logic           srt_we;
  logic [EAW-1:0] srt_ra;
  logic [EAW-1:0] srt_rd;
  logic           spn_we;
  logic [BAW-1:0] spn_wa;
  logic [SW-1:0]  spn_wd;
  logic [BAW-1:0] spn_ra;
  logic [SW-1:0]  spn_rd;

  logic [15:0]    blk_a;
  logic           live_b_less;
  logic [8:0]     new_limit;
  logic [6:0]     cfg_bc;
  logic           out_free;
  logic [CW-1:0]  spn_cnt;
  logic [CW-1:0]  spn_start;
  logic [8:0]     o_start;
  logic [8:0]     o_count;

  assign s_cmd   = s_tuser;
  assign s_block = s_tdata[15:0];
  assign s_order = s_tdata[31:16];
  assign s_del   = s_tdata[32];
  assign s_pos   = s_tdata[40:33];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == gei_pkg::S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign blk_a   = ent_rd_a[15:0];
  assign spn_cnt   = spn_rd[CW-1:0];
  assign spn_start = spn_rd[SW-1:CW];

  assign live_b_less = !ent_rd_b[32] &&
                       ({ent_rd_b[15:0], ent_rd_b[31:16], pj} <
                        {ent_rd_a[15:0], ent_rd_a[31:16], i});

  assign ent_we = s_acc && (s_cmd == gei_pkg::CMD_ADD) && !final_flag &&
                  (32'(entry_total) < 32'(entry_limit)) &&
                  (32'(entry_total) < ENTRY_DEPTH);

  assign srt_we = (state == gei_pkg::S_PUT);
  assign srt_ra = (state == gei_pkg::S_IDLE) ? EAW'(s_pos) : EAW'(q_pos);

  always_comb begin
    spn_we = 1'b0;
    spn_wa = '0;
    spn_wd = '0;
    case (state)
      gei_pkg::S_CLR: begin
        spn_we = (b != span_total);
        spn_wa = BAW'(b);
      end
      gei_pkg::S_PUT: begin
        spn_we = (32'(blk_a) < 32'(span_total));
        spn_wa = BAW'(blk_a);
        spn_wd = {spn_start, spn_cnt + CW'(1)};
      end
      gei_pkg::S_PFX_RD: begin
        spn_we = pfx_wr;
        spn_wa = BAW'(b);
        spn_wd = {prefix, spn_cnt};
      end
      default: begin
        spn_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      gei_pkg::S_IDLE:   spn_ra = BAW'(s_block);
      gei_pkg::S_SCAN:   spn_ra = BAW'(blk_a);
      gei_pkg::S_PUT:    spn_ra = BAW'(blk_a);
      gei_pkg::S_PFX_RD: spn_ra = BAW'(b);
      default:           spn_ra = BAW'(q_blk);
    endcase
  end

  gei_ent_mem #(.W(EW), .D(ENTRY_DEPTH)) u_ent (
    .clk  (clk),
    .we   (ent_we),
    .wa   (EAW'(entry_total)),
    .wd   ({s_del, s_order, s_block}),
    .ra_a (EAW'(i)),
    .rd_a (ent_rd_a),
    .ra_b (EAW'(j)),
    .rd_b (ent_rd_b)
  );

  gei_ram #(.W(EAW), .D(ENTRY_DEPTH)) u_srt (
    .clk (clk),
    .we  (srt_we),
    .wa  (EAW'(rank)),
    .wd  (EAW'(i)),
    .ra  (srt_ra),
    .rd  (srt_rd)
  );

  gei_ram #(.W(SW), .D(BD)) u_spn (
    .clk (clk),
    .we  (spn_we),
    .wa  (spn_wa),
    .wd  (spn_wd),
    .ra  (spn_ra),
    .rd  (spn_rd)
  );

  assign new_limit = (cfg_data != 9'd0 && cfg_data < entry_limit) ? cfg_data : entry_limit;
  assign cfg_bc    = cfg_data[6:0];

  always_comb begin
    o_start = 9'(spn_start);
    o_count = 9'(spn_cnt);
    if (spn_cnt == '0 && (!ne_any || 32'(q_blk) > 32'(last_ne))) begin
      o_start = 9'(live_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gei_pkg::S_IDLE;
      entry_limit <= 9'(ENTRY_DEPTH);
      blocks_cfg  <= '0;
      entry_total <= '0;
      live_total  <= '0;
      span_total  <= '0;
      final_flag  <= 1'b0;
      limit_flag  <= 1'b0;
      ne_any      <= 1'b0;
      last_ne     <= '0;
      m_tvalid    <= 1'b0;
      pv          <= 1'b0;
      pfx_wr      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == gei_pkg::CFG_LIMIT) begin
          entry_limit <= new_limit;
          if (32'(entry_total) > 32'(new_limit) || 32'(blocks_cfg) > 32'(new_limit)) begin
            limit_flag <= 1'b1;
          end
        end else begin
          blocks_cfg <= (32'(cfg_bc) > BLOCK_DEPTH) ? BCW'(BLOCK_DEPTH) : BCW'(cfg_bc);
        end
      end
      case (state)
        gei_pkg::S_IDLE: begin
          if (s_acc) begin
            cmd        <= s_cmd;
            q_blk      <= s_block;
            q_pos      <= s_pos;
            res_status <= gei_pkg::ST_OK;
            res_id     <= 8'd0;
            state      <= gei_pkg::S_RESP;
            case (s_cmd)
              gei_pkg::CMD_ADD: begin
                if (final_flag) begin
                  res_status <= gei_pkg::ST_FINAL;
                end else if (!ent_we) begin
                  res_status <= gei_pkg::ST_FULL;
                  limit_flag <= 1'b1;
                end else begin
                  res_id      <= 8'(entry_total);
                  entry_total <= entry_total + CW'(1);
                end
              end
              gei_pkg::CMD_REBUILD: begin
                final_flag <= 1'b1;
                span_total <= blocks_cfg;
                ne_any     <= 1'b0;
                last_ne    <= '0;
                b          <= '0;
                i          <= '0;
                live_n     <= '0;
                state      <= gei_pkg::S_CLR;
              end
              default: begin
                res_status <= gei_pkg::ST_OK;
              end
            endcase
          end
        end
        gei_pkg::S_CLR: begin
          if (b == span_total) begin
            state <= gei_pkg::S_ROWI;
          end else begin
            b <= b + BCW'(1);
          end
        end
        gei_pkg::S_ROWI: begin
          if (i == entry_total) begin
            live_total <= live_n;
            b          <= '0;
            prefix     <= '0;
            pfx_wr     <= 1'b0;
            state      <= gei_pkg::S_PFX_RD;
          end else begin
            state <= gei_pkg::S_ROWD;
          end
        end
        gei_pkg::S_ROWD: begin
          if (ent_rd_a[32]) begin
            i     <= i + CW'(1);
            state <= gei_pkg::S_ROWI;
          end else begin
            j     <= '0;
            pv    <= 1'b0;
            rank  <= '0;
            state <= gei_pkg::S_SCAN;
          end
        end
        gei_pkg::S_SCAN: begin
          if (pv && live_b_less) begin
            rank <= rank + CW'(1);
          end
          if (j != entry_total) begin
            pj <= j;
            pv <= 1'b1;
            j  <= j + CW'(1);
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              state <= gei_pkg::S_PUT;
            end
          end
        end
        gei_pkg::S_PUT: begin
          live_n <= live_n + CW'(1);
          i      <= i + CW'(1);
          state  <= gei_pkg::S_ROWI;
        end
        gei_pkg::S_PFX_RD: begin
          if (pfx_wr) begin
            prefix <= prefix + spn_cnt;
            if (spn_cnt != '0) begin
              ne_any  <= 1'b1;
              last_ne <= b;
            end
            b      <= b + BCW'(1);
            pfx_wr <= 1'b0;
          end else if (b == span_total) begin
            state <= gei_pkg::S_RESP;
          end else begin
            pfx_wr <= 1'b1;
          end
        end
        gei_pkg::S_RESP: begin
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tdata[1:0]   <= res_status;
            m_tdata[9:2]   <= res_id;
            m_tdata[18:10] <= 9'd0;
            m_tdata[27:19] <= 9'd0;
            m_tdata[36:28] <= 9'(live_total);
            m_tdata[37]    <= final_flag;
            m_tdata[38]    <= limit_flag;
            m_tdata[39]    <= 1'b0;
            if (cmd == gei_pkg::CMD_SPAN) begin
              if (32'(q_blk) >= 32'(span_total) || 32'(q_blk) >= BLOCK_DEPTH) begin
                m_tdata[1:0] <= gei_pkg::ST_RANGE;
              end else begin
                m_tdata[18:10] <= o_start;
                m_tdata[27:19] <= o_count;
              end
            end else if (cmd == gei_pkg::CMD_READ) begin
              if (32'(q_pos) >= 32'(live_total) || 32'(q_pos) >= ENTRY_DEPTH) begin
                m_tdata[1:0] <= gei_pkg::ST_RANGE;
              end else begin
                m_tdata[9:2] <= 8'(srt_rd);
              end
            end
            state <= gei_pkg::S_IDLE;
          end
        end
        default: begin
          state <= gei_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/gei_checker.sv]
module gei_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = gei_pkg::ENTRY_DEPTH_DEF;
  localparam int NB = gei_pkg::BLOCK_DEPTH_DEF;

  typedef struct packed {
    logic       limit_hit;
    logic       is_final;
    logic [8:0] live_count;
    logic [8:0] span_count;
    logic [8:0] span_start;
    logic [7:0] entry_id;
    logic [1:0] status;
  } reply_t;

  logic [15:0] ent_block [NE];
  logic [15:0] ent_order [NE];
  logic        ent_dead  [NE];
  int          sorted    [NE];
  int          blk_start [NB];
  int          blk_cnt   [NB];
  int          ent_total, live_total, span_total, ent_limit, blk_cfg;
  bit          final_f, limit_f;
  reply_t      replies_due [$];

  function automatic logic [47:0] order_key(int id);
    return {ent_block[id], ent_order[id], id[15:0]};
  endfunction

  function automatic void rebuild_index();
    int n, j, b, nxt;
    n = 0;
    for (int i = 0; i < ent_total; i++) begin
      if (!ent_dead[i]) begin
        j = n;
        while (j > 0 && order_key(sorted[j-1]) > order_key(i)) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = i;
        n++;
      end
    end
    live_total = n;
    span_total = blk_cfg;
    for (int i = 0; i < span_total; i++) begin
      blk_start[i] = 0;
      blk_cnt[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      b = ent_block[sorted[i]];
      if (b < span_total) begin
        if (blk_cnt[b] == 0) blk_start[b] = i;
        blk_cnt[b]++;
      end
    end
    nxt = n;
    for (int i = span_total - 1; i >= 0; i--) begin
      if (blk_cnt[i] == 0) blk_start[i] = nxt;
      else nxt = blk_start[i];
    end
  endfunction

  function automatic reply_t predict_reply(logic [1:0] cmd, logic [47:0] d);
    reply_t r;
    logic [15:0] blk, ord;
    logic        del;
    logic [7:0]  pos;
    blk = d[15:0];
    ord = d[31:16];
    del = d[32];
    pos = d[40:33];
    r = '0;
    r.status = gei_pkg::ST_OK;
    case (cmd)
      gei_pkg::CMD_ADD: begin
        if (final_f) begin
          r.status = gei_pkg::ST_FINAL;
        end else if (ent_total >= ent_limit || ent_total >= NE) begin
          limit_f = 1;
          r.status = gei_pkg::ST_FULL;
        end else begin
          ent_block[ent_total] = blk;
          ent_order[ent_total] = ord;
          ent_dead[ent_total] = del;
          r.entry_id = ent_total[7:0];
          ent_total++;
        end
      end
      gei_pkg::CMD_REBUILD: begin
        rebuild_index();
        final_f = 1;
      end
      gei_pkg::CMD_SPAN: begin
        if (blk >= span_total || blk >= NB) begin
          r.status = gei_pkg::ST_RANGE;
        end else begin
          r.span_start = blk_start[blk][8:0];
          r.span_count = blk_cnt[blk][8:0];
        end
      end
      default: begin
        if (pos >= live_total) r.status = gei_pkg::ST_RANGE;
        else r.entry_id = sorted[pos][7:0];
      end
    endcase
    r.live_count = live_total[8:0];
    r.is_final = final_f;
    r.limit_hit = limit_f;
    return r;
  endfunction

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t e, a;
    if (rst) begin
      errors = 0;
      ent_limit = NE;
      blk_cfg = 0;
      ent_total = 0;
      live_total = 0;
      span_total = 0;
      final_f = 0;
      limit_f = 0;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gei_pkg::CFG_LIMIT) begin
          if (cfg_data != 0 && cfg_data < ent_limit) ent_limit = cfg_data;
          if (ent_total > ent_limit || blk_cfg > ent_limit) limit_f = 1;
        end else begin
          blk_cfg = (cfg_data[6:0] > NB) ? NB : cfg_data[6:0];
        end
      end
      if (m_tvalid && m_tready) begin
        a = m_tdata[38:0];
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          e = replies_due.pop_front();
          check_field("status", e.status, a.status);
          check_field("entry_id", e.entry_id, a.entry_id);
          check_field("span_start", e.span_start, a.span_start);
          check_field("span_count", e.span_count, a.span_count);
          check_field("live_count", e.live_count, a.live_count);
          check_field("is_final", e.is_final, a.is_final);
          check_field("limit_hit", e.limit_hit, a.limit_hit);
        end
      end
      if (s_tvalid && s_tready) begin
        replies_due = {replies_due, predict_reply(s_tuser, s_tdata)};
      end
    end
    pending = replies_due.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          errors, pending;
  int          burst_left = 0;
  int          sink_mode = 0;
  int          sink_cnt = 0;

  block_grouped_entry_index_core u_dut (.*);

  gei_checker u_check (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #24ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    sink_cnt <= sink_cnt + 1;
    if (sink_cnt % 150 == 0) sink_mode <= $urandom_range(0, 2);
    case (sink_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] blk, logic [15:0] ord,
                           logic del, logic [7:0] pos);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, pos, del, ord, blk};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_block();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 70));
    if (r < 9) return 16'($urandom_range(0, 7));
    return 16'($urandom);
  endfunction

  task automatic send_add();
    send_item(gei_pkg::CMD_ADD, pick_block(),
              ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
              ($urandom_range(0, 3) == 0), 8'($urandom));
  endtask

  task automatic send_query();
    if ($urandom_range(0, 1)) begin
      send_item(gei_pkg::CMD_SPAN, pick_block(), 16'($urandom), 1'($urandom),
                8'($urandom));
    end else begin
      send_item(gei_pkg::CMD_READ, 16'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
    end
  endtask

  initial begin
    logic [8:0] blk_setting [5];
    blk_setting = '{9'd0, 9'd64, 9'd127, 9'd1, 9'd0};
    blk_setting[4] = 9'($urandom_range(2, 63));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(gei_pkg::CFG_LIMIT, 9'd0);
    write_reg(gei_pkg::CFG_LIMIT, 9'h1FF);
    write_reg(gei_pkg::CFG_BLOCKS, 9'd127);

    send_item(gei_pkg::CMD_SPAN, 16'd0, 16'd0, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_SPAN, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    send_item(gei_pkg::CMD_READ, 16'd0, 16'd0, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    send_item(gei_pkg::CMD_ADD, 16'd0, 16'd0, 1'b0, 8'hFF);
    send_item(gei_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd63, 16'hFFFF, 1'b1, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd64, 16'd0, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd0, 16'd0, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd5, 16'd2, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd5, 16'd1, 1'b0, 8'd0);
    send_item(gei_pkg::CMD_ADD, 16'd2, 16'd9, 1'b1, 8'd0);

    wait_idle();
    write_reg(gei_pkg::CFG_LIMIT, 9'd250);
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 99) < 85) send_add();
      else send_query();
    end
    wait_idle();
    write_reg(gei_pkg::CFG_LIMIT, 9'd100);
    write_reg(gei_pkg::CFG_LIMIT, 9'd256);

    for (int r = 0; r < 5; r++) begin
      wait_idle();
      write_reg(gei_pkg::CFG_BLOCKS, blk_setting[r]);
      send_item(gei_pkg::CMD_REBUILD, 16'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) == 0) send_add();
        else send_query();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
